FILE: rtl/rwct_pkg.sv
`default_nettype none
package rwct_pkg;

  localparam int FUNC_COLUMN = 0;
  localparam int FUNC_ROW    = 1;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] REGION_CEIL  = 2'd0;
  localparam logic [1:0] REGION_WALL  = 2'd1;
  localparam logic [1:0] REGION_FLOOR = 2'd2;

  localparam logic [1:0] REG_ROWS       = 2'd0;
  localparam logic [1:0] REG_CEIL_RGBA  = 2'd1;
  localparam logic [1:0] REG_FLOOR_RGBA = 2'd2;

  localparam logic [1:0] FACE_NORTH = 2'd0;
  localparam logic [1:0] FACE_EAST  = 2'd3;

  // one decoded input word, queued between front and back
  typedef struct packed {
    logic        func;
    logic [10:0] column;
    logic [23:0] pos;
    logic [17:0] dir;
    logic [23:0] hit_dist;
    logic        mirror;
    logic [1:0]  face;
  } rwct_item_t;

endpackage
`default_nettype wire

FILE: rtl/rwct_front.sv
`default_nettype none
// Accept input words, pick the axis by hit side, and queue them.
module rwct_front
  import rwct_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [127:0] in_data,
  input  wire logic       in_func,
  output logic            q_valid,
  input  wire logic       q_pop,
  output rwct_item_t      q_item
);
  localparam int DEPTH = QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);

  rwct_item_t    mem [DEPTH];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;
  rwct_item_t    item;
  logic          push, pop;
  logic          side;
  logic [1:0]    face;

  assign side = in_data[119];
  assign face = in_data[121:120];

  always_comb begin
    item.func     = in_func;
    item.column   = in_data[10:0];
    item.pos      = side ? in_data[34:11] : in_data[58:35];
    item.dir      = side ? in_data[76:59] : in_data[94:77];
    item.hit_dist = in_data[118:95];
    item.mirror   = side ? (face == FACE_NORTH) : (face == FACE_EAST);
    item.face     = face;
  end

  assign in_ready = count != (AW+1)'(DEPTH);
  assign q_valid  = count != '0;
  assign q_item   = mem[rptr];
  assign push = in_valid && in_ready;
  assign pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(DEPTH-1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(DEPTH-1)) ? '0 : rptr + 1'b1;
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rwct_divider.sv
`default_nettype none
// Restoring divider, one quotient bit a cycle.
module rwct_divider #(
  parameter int W = 44
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] num,
  input  wire logic [W-1:0] den,
  output logic              busy,
  output logic [W-1:0]      quo
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0] rem, q, d;
  logic [CW-1:0] cnt;
  logic [W:0]   trial;

  assign trial = {rem, q[W-1]} - {1'b0, d};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= num;
      d   <= den;
    end else if (busy) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        q   <= {q[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], q[W-1]};
        q   <= {q[W-2:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/rwct_back.sv
`default_nettype none
// Column setup sequencer and row emitter.
module rwct_back
  import rwct_pkg::*;
#(
  parameter int TEX_SIZE  = 64,
  parameter int FRAC_BITS = 16,
  parameter int MAX_ROWS  = 2048
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [11:0] rows_cfg,
  input  wire logic [31:0] ceil_rgba,
  input  wire logic [31:0] floor_rgba,
  input  wire logic        q_valid,
  output logic             q_pop,
  input  wire rwct_item_t  q_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [71:0]      out_word
);
  localparam int TB  = $clog2(TEX_SIZE);
  localparam int DW  = 2 * FRAC_BITS + 13;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV1  = 6'b000010,
    S_GEOM  = 6'b000100,
    S_DIV2  = 6'b001000,
    S_MUL   = 6'b010000,
    S_TEX   = 6'b100000
  } state_t;

  state_t state;
  logic [12:0] h, center;
  logic [DW-1:0] div_num, div_den, div_q;
  logic div_start, div_busy;
  logic [DW-1:0] lh, half;
  logic [12:0] top, bottom;
  logic [31:0] step;
  logic [31:0] off;
  logic signed [43:0] prod;
  logic [63:0] frac_sum;
  logic [2*FRAC_BITS-1:0] frac;
  logic [TB-1:0] t;

  logic [10:0] cur_column, line_top_row, line_bottom_row;
  logic [11:0] row_counter;
  logic [TB-1:0] tex_column;
  logic [1:0] face_reg;
  logic [31:0] tex_step, tex_accum;
  rwct_item_t cur;

  logic row_go, row_fire, is_wall;
  logic [12:0] row13;
  logic [71:0] row_word;

  always_comb begin
    h = {1'b0, rows_cfg};
    if (h < 13'd2) h = 13'd2;
    if (h > 13'(MAX_ROWS)) h = 13'(MAX_ROWS);
    center = h >> 1;
  end

  rwct_divider #(.W(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quo(div_q)
  );

  // row path
  assign row13 = {1'b0, row_counter};
  assign is_wall = row_counter >= {1'b0, line_top_row} &&
                   row_counter <= {1'b0, line_bottom_row};
  assign row_go = state == S_IDLE && q_valid && q_item.func
                  && (!out_valid || out_ready);
  assign row_fire = row_go && row13 < h;
  assign q_pop = state == S_IDLE && q_valid &&
                 (!q_item.func || !out_valid || out_ready);

  always_comb begin
    row_word = '0;
    row_word[10:0]  = cur_column;
    row_word[21:11] = row_counter[10:0];
    row_word[70]    = row13 == h - 13'd1;
    if (is_wall) begin
      row_word[23:22] = REGION_WALL;
      row_word[57:56] = face_reg;
      row_word[63:58] = 6'(tex_column);
      row_word[69:64] = 6'(tex_accum[FRAC_BITS +: TB]);
    end else if (row13 < center) begin
      row_word[23:22] = REGION_CEIL;
      row_word[55:24] = ceil_rgba;
    end else begin
      row_word[23:22] = REGION_FLOOR;
      row_word[55:24] = floor_rgba;
    end
  end

  always_comb begin
    half   = lh >> 1;
    top    = (half > DW'(center)) ? 13'd0 : center - half[12:0];
    bottom = (DW'(center) + half > DW'(h - 13'd1)) ? h - 13'd1
             : center + half[12:0];
  end

  assign frac_sum = ({40'b0, cur.pos} << FRAC_BITS) + 64'(prod);
  assign frac = (cur.hit_dist == 24'd0) ? (2*FRAC_BITS)'({40'b0, cur.pos} << FRAC_BITS)
                                        : frac_sum[2*FRAC_BITS-1:0];
  assign t = frac[2*FRAC_BITS-1 -: TB];

  always_comb begin
    div_start = 1'b0;
    div_num = '0;
    div_den = '0;
    if (state == S_IDLE && q_valid && !q_item.func) begin
      div_start = 1'b1;
      div_num = DW'(h) << FRAC_BITS;
      div_den = (q_item.hit_dist == 24'd0) ? DW'(1) : DW'(q_item.hit_dist);
    end else if (state == S_GEOM) begin
      // line height is on the divider output this cycle
      div_start = div_q != '0;
      div_num = DW'(TEX_SIZE) << FRAC_BITS;
      div_den = div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      cur_column <= '0; row_counter <= '0;
      line_top_row <= '0; line_bottom_row <= '0;
      tex_column <= '0; face_reg <= '0;
      tex_step <= '0; tex_accum <= '0;
    end else begin
      if (row_fire) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && !q_item.func) begin
            cur <= q_item;
            state <= S_DIV1;
          end else if (row_fire) begin
            out_word <= row_word;
            if (is_wall) tex_accum <= tex_accum + tex_step;
            row_counter <= row_counter + 12'd1;
          end
        end
        S_DIV1: if (!div_busy && !div_start) state <= S_GEOM;
        S_GEOM: begin
          lh <= div_q;
          state <= S_DIV2;
        end
        S_DIV2: if (!div_busy) begin
          if (lh == '0 || div_q > DW'(32'hFFFFFFFF)) step <= 32'hFFFFFFFF;
          else step <= div_q[31:0];
          off <= 32'(top) + 32'(half) - 32'(center);
          prod <= 44'($signed(cur.hit_dist == 24'd0 ? 25'd1 : {1'b0, cur.hit_dist}))
                  * 44'($signed(cur.dir));
          state <= S_MUL;
        end
        S_MUL: begin
          tex_accum <= off * step;
          state <= S_TEX;
        end
        default: begin
          cur_column <= cur.column;
          row_counter <= '0;
          line_top_row <= top[10:0];
          line_bottom_row <= bottom[10:0];
          tex_column <= cur.mirror ? TB'(TEX_SIZE - 1) - t : t;
          face_reg <= cur.face;
          tex_step <= step;
          state <= S_IDLE;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/raycast_wall_column_texturer.sv
`default_nettype none
// channel   dir  fields (low bit up)
// s_axis    in   tuser=func; tdata=column,pos_x,pos_y,dir_x,dir_y,
//                distance,hit_side,face
// m_axis    out  tdata=out_column,out_row,region,fill_color,texture_face,
//                texel_x,texel_y,last_row
// cfg       in   wr_en, wr_index, wr_data
// Row words take one cycle each. A column word holds the back end through two
// 45-step serial divisions (the second is skipped when the line height is zero);
// a 4-entry queue keeps input flowing meanwhile and drops tready when full.
// Reset is synchronous. Output stalls hold the row stream.
module raycast_wall_column_texturer
  import rwct_pkg::*;
#(
  parameter int TEX_SIZE  = 64,
  parameter int FRAC_BITS = 16,
  parameter int MAX_ROWS  = 2048
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [127:0] s_axis_tdata,  // column..face
  input  wire logic         s_axis_tuser,  // func
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [71:0]       m_axis_tdata,  // out_column..last_row
  input  wire logic         wr_en,
  input  wire logic [1:0]   wr_index,
  input  wire logic [31:0]  wr_data
);
  logic [11:0] rows_cfg;
  logic [31:0] ceil_rgba, floor_rgba;
  logic q_valid, q_pop;
  rwct_item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_cfg <= 12'd480;
      ceil_rgba <= '0;
      floor_rgba <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROWS:       rows_cfg <= wr_data[11:0];
        REG_CEIL_RGBA:  ceil_rgba <= wr_data;
        REG_FLOOR_RGBA: floor_rgba <= wr_data;
        default: ;
      endcase
    end
  end

  rwct_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_func(s_axis_tuser),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  rwct_back #(.TEX_SIZE(TEX_SIZE), .FRAC_BITS(FRAC_BITS), .MAX_ROWS(MAX_ROWS)) u_back (
    .clk(clk), .rst(rst), .rows_cfg(rows_cfg),
    .ceil_rgba(ceil_rgba), .floor_rgba(floor_rgba),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_word(m_axis_tdata)
  );
endmodule
`default_nettype wire
